>>> src/rmbs_pkg.sv
// ----------------------------------------------------------------------------
// Row median by sort package
// Shared constants, types and register indexes of the row median block.
// ----------------------------------------------------------------------------
package rmbs_pkg;

    localparam int MAX_ROW_LENGTH = 8;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int MED_W          = SAMPLE_WIDTH + 1;
    localparam int CNT_W          = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
    localparam int LEN_W          = $clog2(MAX_ROW_LENGTH + 1);
    localparam int CFG_LEN_W      = 4;
    localparam int ROW_W          = 8;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;

    localparam logic REG_ROW_LENGTH     = 1'b0;
    localparam logic REG_ROWS_PER_MATRIX = 1'b1;

    localparam logic [CFG_LEN_W-1:0] ROW_LENGTH_RESET      = CFG_LEN_W'(8);
    localparam logic [ROW_W-1:0]     ROWS_PER_MATRIX_RESET = ROW_W'(2);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [MED_W-1:0]        t_med;

    typedef struct packed {
        logic [LEN_W-1:0] row_len;
        logic [ROW_W-1:0] rows;
        logic             clear;
    } t_cfg;

    typedef struct packed {
        t_sample          lo;
        t_sample          hi;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_mid_pair;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [ROW_W-1:0] row;
    } t_front_status;

endpackage

>>> src/rmbs_front.sv
// ----------------------------------------------------------------------------
// Row median front end
// Inserts each sample into a sorted register row and, when a row is
// complete, hands its two middle values and row number to the queue.
// ----------------------------------------------------------------------------
module rmbs_front
    import rmbs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_accept,
    input  t_sample       i_sample,
    output logic          o_push,
    output t_mid_pair     o_pair,
    output t_front_status o_status
);

    t_sample          r_sorted [MAX_ROW_LENGTH];
    t_sample          n_sorted [MAX_ROW_LENGTH];
    logic             gt       [MAX_ROW_LENGTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [CNT_W-1:0] last_idx;
    logic [CNT_W-1:0] hi_idx;
    logic [CNT_W-1:0] lo_idx;
    logic             row_done;
    logic             last;

    always_comb begin
        for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
            gt[i] = (CNT_W'(i) < r_count) ? (r_sorted[i] > i_sample) : 1'b1;
        end
        for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
            if (!gt[i]) begin
                n_sorted[i] = r_sorted[i];
            end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                n_sorted[i] = r_sorted[(i > 0) ? i - 1 : 0];
            end else begin
                n_sorted[i] = i_sample;
            end
        end
    end

    assign last_idx = CNT_W'(i_cfg.row_len - LEN_W'(1));
    assign hi_idx   = CNT_W'(i_cfg.row_len >> 1);
    assign lo_idx   = i_cfg.row_len[0] ? hi_idx : hi_idx - CNT_W'(1);
    assign row_done = i_accept && (r_count == last_idx);
    assign last     = (r_row >= i_cfg.rows);

    always_comb begin
        n_count = r_count;
        n_row   = r_row;
        if (i_cfg.clear) begin
            n_count = '0;
        end else if (i_accept) begin
            if (row_done) begin
                n_count = '0;
                n_row   = last ? ROW_W'(1) : r_row + ROW_W'(1);
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_row   <= ROW_W'(1);
        end else begin
            r_count <= n_count;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
                r_sorted[i] <= n_sorted[i];
            end
        end
    end

    assign o_push         = row_done;
    assign o_pair.lo      = n_sorted[lo_idx];
    assign o_pair.hi      = n_sorted[hi_idx];
    assign o_pair.row     = r_row;
    assign o_pair.last    = last;
    assign o_status.count = r_count;
    assign o_status.row   = r_row;

endmodule

>>> src/rmbs_queue.sv
// ----------------------------------------------------------------------------
// Row median queue
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
module rmbs_queue
    import rmbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_mid_pair i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_mid_pair o_data
);

    t_mid_pair         r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

>>> src/rmbs_back.sv
// ----------------------------------------------------------------------------
// Row median back end
// Adds the two middle values of a row and holds the result for the reader.
// ----------------------------------------------------------------------------
module rmbs_back
    import rmbs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_mid_pair        i_q_data,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output t_med             o_median_doubled,
    output logic [ROW_W-1:0] o_row_number,
    output logic             o_last_row
);

    logic             r_valid;
    t_med             r_med;
    logic [ROW_W-1:0] r_row;
    logic             r_last;
    logic             load;

    assign load    = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_med  <= {i_q_data.lo[SAMPLE_WIDTH-1], i_q_data.lo}
                    + {i_q_data.hi[SAMPLE_WIDTH-1], i_q_data.hi};
            r_row  <= i_q_data.row;
            r_last <= i_q_data.last;
        end
    end

    assign o_empty          = !r_valid;
    assign o_median_doubled = r_med;
    assign o_row_number     = r_row;
    assign o_last_row       = r_last;

endmodule

>>> src/row_median_by_sort.sv
// ----------------------------------------------------------------------------
// Row median by sort
// Groups samples into rows, sorts each row and gives twice its median.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the queue is not full, set by the
// insertion-sort register row. Path: the last sample of a row writes its middle
// pair into the queue, then the adder stage registers the result once it is free.
// Reset: synchronous; row length returns to 8, rows per matrix to 2, the row
// number to 1 and the partial row, queue and output stage are emptied.
// ----------------------------------------------------------------------------
module row_median_by_sort
    import rmbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  t_sample           i_sample,
    output logic              empty,
    input  logic              pop,
    output t_med              o_median_doubled,
    output logic [ROW_W-1:0]  o_row_number,
    output logic              o_last_row
);

    logic [CFG_LEN_W-1:0] r_row_length;
    logic [ROW_W-1:0]     r_rows_per_matrix;
    logic                 cfg_write;
    logic                 reg_idx;
    t_cfg                 cfg;
    logic                 accept;
    logic                 f_push;
    t_mid_pair            f_pair;
    t_front_status        f_status;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    t_mid_pair            q_data;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length      <= ROW_LENGTH_RESET;
            r_rows_per_matrix <= ROWS_PER_MATRIX_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_ROW_LENGTH:      r_row_length      <= pwdata[CFG_LEN_W-1:0];
                REG_ROWS_PER_MATRIX: r_rows_per_matrix <= pwdata[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_LENGTH:      prdata = DATA_W'(r_row_length);
            REG_ROWS_PER_MATRIX: prdata = DATA_W'(r_rows_per_matrix);
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        if (r_row_length == '0) begin
            cfg.row_len = LEN_W'(1);
        end else if (r_row_length > CFG_LEN_W'(MAX_ROW_LENGTH)) begin
            cfg.row_len = LEN_W'(MAX_ROW_LENGTH);
        end else begin
            cfg.row_len = LEN_W'(r_row_length);
        end
        cfg.rows  = (r_rows_per_matrix == '0) ? ROW_W'(1) : r_rows_per_matrix;
        cfg.clear = cfg_write && (reg_idx == REG_ROW_LENGTH);
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    rmbs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_sample (i_sample),
        .o_push   (f_push),
        .o_pair   (f_pair),
        .o_status (f_status)
    );

    rmbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_pair),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    rmbs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_data         (q_data),
        .o_q_pop          (q_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_median_doubled (o_median_doubled),
        .o_row_number     (o_row_number),
        .o_last_row       (o_last_row)
    );

    a_no_queue_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full)
        else $error("Row pushed into a full queue.");

    a_count_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LEN_W'(f_status.count) < cfg.row_len)
        else $error("Sample count reached the row length.");

    a_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_status.row != '0)
        else $error("Row counter is zero.");

    a_result_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_row_number != '0)
        else $error("Result carries row number zero.");

endmodule
